@@ design/cmdq_pkg.sv @@
// ---------------------------------------------------------------------------
// cmdq_pkg
// Shared sizes, codes and helpers of the command line queue.
// ---------------------------------------------------------------------------
package cmdq_pkg;

	// queue geometry
	localparam int LINE_SLOTS = 16;
	localparam int LINE_CHARS = 64;

	localparam int SLOT_W = $clog2(LINE_SLOTS);
	localparam int LEN_W  = $clog2(LINE_CHARS + 1);
	localparam int CNT_W  = $clog2(LINE_SLOTS + 1);
	localparam int ADDR_W = $clog2(LINE_SLOTS * LINE_CHARS);

	// port field widths
	localparam int ACT_W  = 2;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 7;
	localparam int STAT_W = 2;
	localparam int FPOS_W = 7;
	localparam int HELD_W = 5;
	localparam int CMP_W  = (IDX_W > LEN_W) ? IDX_W : LEN_W;

	// action codes
	localparam logic [ACT_W-1:0] ACT_RECEIVE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIND    = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// special characters
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

	// ring successor of a slot
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(LINE_SLOTS - 1)) r = '0;
		else r = s + 1'b1;
		return r;
	endfunction

	// character store address of a position within a slot
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
			input logic [LEN_W-1:0] pos);
		return ADDR_W'(slot) * ADDR_W'(LINE_CHARS) + ADDR_W'(pos);
	endfunction

endpackage

@@ design/command_line_queue_core.sv @@
// ---------------------------------------------------------------------------
// command_line_queue_core
// Serial command line assembler with a ring of line slots in block RAM.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one item per action: receive a
// byte, read a character of the head line, search the head line, or release
// the head line. Output channel (out_valid / out_stall) returns one result
// item per input item, in order.
// Timing: an item is taken only while the sequencer is idle. Receive and
// release finish in the execute state, a character read also passes the
// read state (one RAM read), a search the find state, paced by the single
// read port of the character store, walked one character per cycle.
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds a finished item in its last state until
// the output register frees, so nothing is lost.
// Reset clears the ring pointers, line count, assembly count and comment
// flag; the character store and length table need no clearing, since only
// entries of queued lines are ever read.
// ---------------------------------------------------------------------------
module command_line_queue_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cmdq_pkg::ACT_W-1:0]   action,
	input  logic [cmdq_pkg::BYTE_W-1:0]  data_byte,
	input  logic [cmdq_pkg::IDX_W-1:0]   char_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cmdq_pkg::STAT_W-1:0]  status,
	output logic                         line_queued,
	output logic [cmdq_pkg::BYTE_W-1:0]  head_char,
	output logic                         found,
	output logic [cmdq_pkg::FPOS_W-1:0]  found_position,
	output logic [cmdq_pkg::HELD_W-1:0]  lines_held
);
	import cmdq_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_READ, ST_FIND} state_t;

	state_t              state_q;
	logic [ACT_W-1:0]    act_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    used_q;
	logic [LEN_W-1:0]    asm_q;
	logic                comment_q;
	logic [LEN_W-1:0]    len_q [LINE_SLOTS];
	logic                hit_q;
	logic [LEN_W-1:0]    scan_q;
	logic                cmp_vld_s1;
	logic [LEN_W-1:0]    cmp_idx_s1;

	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic                queued_q;
	logic [BYTE_W-1:0]   hchar_q;
	logic                found_q;
	logic [FPOS_W-1:0]   fpos_q;
	logic [HELD_W-1:0]   held_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	logic [LEN_W-1:0]    head_len;
	logic                empty;
	logic                full;
	logic                is_eol;
	logic                is_semi;
	logic                out_free;
	logic                in_range;
	logic                match;
	logic                finish;
	logic                commit;
	logic [STAT_W-1:0]   res_status;
	logic                res_queued;
	logic [BYTE_W-1:0]   res_hchar;
	logic                res_found;
	logic [FPOS_W-1:0]   res_fpos;
	logic [CNT_W-1:0]    res_used;

	// character store
	cmdq_ram #(
		.DEPTH(LINE_SLOTS * LINE_CHARS),
		.WIDTH(BYTE_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(byte_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// status of the queue and of the held item
	assign head_len = len_q[head_q];
	assign empty    = (used_q == '0);
	assign full     = (used_q == CNT_W'(LINE_SLOTS));
	assign is_eol   = (byte_q == CH_LF) || (byte_q == CH_CR);
	assign is_semi  = (byte_q == CH_SEMI);
	assign out_free = !out_valid_q || !out_stall;
	assign in_range = (CMP_W'(idx_q) < CMP_W'(head_len));
	assign match    = cmp_vld_s1 && (ram_rdata == byte_q);
	assign finish   = match || (!cmp_vld_s1 && (scan_q >= head_len));
	assign in_stall = (state_q != ST_IDLE);

	// result and store access of the current step
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = slot_addr(tail_q, asm_q);
		ram_re     = 1'b0;
		ram_raddr  = slot_addr(head_q, scan_q);
		commit     = 1'b0;
		res_status = STAT_DONE;
		res_queued = 1'b0;
		res_hchar  = '0;
		res_found  = 1'b0;
		res_fpos   = '0;
		res_used   = used_q;
		case (state_q)
			ST_EXEC: begin
				case (act_q)
					ACT_RECEIVE: begin
						commit = out_free;
						if (full) begin
							res_status = STAT_FULL;
						end else if (is_eol) begin
							if (asm_q != '0) begin
								res_queued = 1'b1;
								res_used   = used_q + 1'b1;
							end
						end else if (asm_q < LEN_W'(LINE_CHARS)) begin
							ram_we = out_free && !is_semi && !comment_q;
						end
					end
					ACT_READ: begin
						if (empty) begin
							commit     = out_free;
							res_status = STAT_EMPTY;
						end else begin
							ram_re    = in_range;
							ram_raddr = slot_addr(head_q, LEN_W'(idx_q));
						end
					end
					ACT_FIND: begin
						if (empty) begin
							commit     = out_free;
							res_status = STAT_EMPTY;
						end
					end
					default: begin
						commit = out_free;
						if (empty) res_status = STAT_EMPTY;
						else res_used = used_q - 1'b1;
					end
				endcase
			end
			ST_READ: begin
				commit    = out_free;
				res_hchar = hit_q ? ram_rdata : '0;
			end
			ST_FIND: begin
				ram_re = !finish && (scan_q < head_len);
				commit = finish && out_free;
				if (match) begin
					res_found = 1'b1;
					res_fpos  = FPOS_W'(cmp_idx_s1);
				end else if (byte_q == '0) begin
					res_found = 1'b1;
					res_fpos  = FPOS_W'(head_len);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, queue state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= '0;
			byte_q      <= '0;
			idx_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			asm_q       <= '0;
			comment_q   <= 1'b0;
			hit_q       <= 1'b0;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			queued_q    <= 1'b0;
			hchar_q     <= '0;
			found_q     <= 1'b0;
			fpos_q      <= '0;
			held_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						byte_q  <= data_byte;
						idx_q   <= char_index;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (act_q)
						ACT_RECEIVE: begin
							if (commit && !full) begin
								if (is_eol) begin
									comment_q <= 1'b0;
									if (asm_q != '0) begin
										tail_q <= next_slot(tail_q);
										used_q <= used_q + 1'b1;
										asm_q  <= '0;
									end
								end else if (asm_q < LEN_W'(LINE_CHARS)) begin
									if (is_semi) comment_q <= 1'b1;
									if (!is_semi && !comment_q) asm_q <= asm_q + 1'b1;
								end
							end
						end
						ACT_READ: begin
							if (!empty) begin
								hit_q   <= in_range;
								state_q <= ST_READ;
							end
						end
						ACT_FIND: begin
							if (!empty) begin
								scan_q     <= '0;
								cmp_vld_s1 <= 1'b0;
								state_q    <= ST_FIND;
							end
						end
						default: begin
							if (commit && !empty) begin
								head_q <= next_slot(head_q);
								used_q <= used_q - 1'b1;
							end
						end
					endcase
				end
				ST_FIND: begin
					if (!finish) begin
						scan_q     <= scan_q + LEN_W'(ram_re);
						cmp_vld_s1 <= ram_re;
						cmp_idx_s1 <= scan_q;
					end
				end
				default: begin
				end
			endcase
			if (commit) begin
				state_q     <= ST_IDLE;
				out_valid_q <= 1'b1;
				status_q    <= res_status;
				queued_q    <= res_queued;
				hchar_q     <= res_hchar;
				found_q     <= res_found;
				fpos_q      <= res_fpos;
				held_q      <= HELD_W'(res_used);
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line length table, written when a line is queued
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && act_q == ACT_RECEIVE && commit && !full && is_eol
				&& asm_q != '0) begin
			len_q[tail_q] <= asm_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign line_queued    = queued_q;
	assign head_char      = hchar_q;
	assign found          = found_q;
	assign found_position = fpos_q;
	assign lines_held     = held_q;

	// line count never exceeds the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(LINE_SLOTS))
		else $error("line count above slot count");

	// partial line never exceeds the line limit
	assert property (@(posedge clk) disable iff (!arst_n)
		asm_q <= LEN_W'(LINE_CHARS))
		else $error("assembly count above line limit");

	// an empty or full ring has head and tail on the same slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0 || used_q == CNT_W'(LINE_SLOTS)) |-> (head_q == tail_q))
		else $error("ring pointers disagree with line count");

	// no character is stored into a full ring
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !full)
		else $error("store write while ring full");

	// a result only appears after the sequencer has worked on an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q != ST_IDLE))
		else $error("result without an item in progress");

endmodule

@@ design/cmdq_ram.sv @@
// ---------------------------------------------------------------------------
// cmdq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module cmdq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
